### rtl/core/sdsfr_pkg.sv
package sdsfr_pkg;

  // Record kinds on the result channel
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // One result item
  typedef struct packed {
    logic       record_kind;
    logic [7:0] data_byte;
    logic [7:0] frame_length;
    logic       overflow;
  } result_t;

endpackage

### rtl/core/syn_dle_stx_frame_receiver.sv
// SYN / DLE-STX frame receiver with DLE unstuffing.
//
// Input channel: one raw serial byte per item on in_rx_byte, handshake
// in_valid / in_stall. The block hunts for SYN..SYN DLE STX, then passes
// payload bytes (DLE DLE -> one DLE) and closes the frame on DLE + any
// other byte with an end record carrying the kept length and overflow.
// Output channel: out_valid / out_stall, zero or one record per byte.
// Config: cfg_wr_en writes cfg_max_payload (payload limit, clamped to
// MAX_LEN); write only while the block is idle.
// Path: a byte accepted into the input register moves through the parse logic
// into the output register, where the record can be taken. Throughput: one
// byte per cycle; the input register drains whenever the output register is
// empty or being taken in the same cycle.
// Reset (rst_n, synchronous, active low): both registers empty, parser
// back to the hunt, limit back to 128.
// Stall: a stalled record holds in the output register; the next byte
// waits in the input register and in_stall rises once that is full too.
module syn_dle_stx_frame_receiver #(
  parameter int MAX_LEN = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_record_kind,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_frame_length,
  output logic       out_overflow,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_max_payload
);

  logic               in_v_r, in_v_nxt;
  logic [7:0]         in_byte_r;
  logic [7:0]         max_payload_r;
  logic               accept;
  logic               step;
  logic               res_valid;
  sdsfr_pkg::result_t res;
  sdsfr_pkg::result_t out_res;

  // held item moves on when the output register can take a record
  assign step     = in_v_r && (!out_valid || !out_stall);
  assign in_stall = in_v_r && !step;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) in_v_nxt = 1'b1;
    else if (step) in_v_nxt = 1'b0;
    else in_v_nxt = in_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r        <= 1'b0;
      max_payload_r <= 8'd128;
    end else begin
      in_v_r <= in_v_nxt;
      if (cfg_wr_en) max_payload_r <= cfg_max_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_byte_r <= in_rx_byte;
  end

  sdsfr_parser #(
    .MAX_LEN(MAX_LEN)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .rx_byte    (in_byte_r),
    .max_payload(max_payload_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  sdsfr_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step && res_valid),
    .res      (res),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  assign out_record_kind  = out_res.record_kind;
  assign out_data_byte    = out_res.data_byte;
  assign out_frame_length = out_res.frame_length;
  assign out_overflow     = out_res.overflow;

`ifndef NO_ASSERTIONS
  // input stage only stalls while holding a byte behind a stalled record
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_v_r && out_valid && out_stall))
    else $error("in_stall without a blocked item");

  // kept length never exceeds the build-time cap
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_record_kind == sdsfr_pkg::KIND_END) |->
      (32'(out_frame_length) <= MAX_LEN))
    else $error("frame length above MAX_LEN");

  // data records carry no length or overflow
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_record_kind == sdsfr_pkg::KIND_DATA) |->
      (out_frame_length == 8'd0 && !out_overflow))
    else $error("data record with end fields set");
`endif

endmodule

### rtl/core/sdsfr_parser.sv
module sdsfr_parser #(
  parameter int MAX_LEN = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         max_payload,
  output logic               res_valid,
  output sdsfr_pkg::result_t res
);

  localparam logic [7:0] MaxLen = 8'(MAX_LEN);

  localparam logic [7:0] BYTE_SYN = 8'h16;
  localparam logic [7:0] BYTE_DLE = 8'h10;
  localparam logic [7:0] BYTE_STX = 8'h02;

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_SYNS   = 3'd1;
  localparam logic [2:0] PH_OPEN   = 3'd2;
  localparam logic [2:0] PH_BODY   = 3'd3;
  localparam logic [2:0] PH_ESCAPE = 3'd4;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] count_r, count_nxt;
  logic       dropped_r, dropped_nxt;
  logic [7:0] limit;
  logic       keep;
  logic       room;

  assign limit = (max_payload > MaxLen) ? MaxLen : max_payload;
  assign room  = (count_r < limit);

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    keep        = 1'b0;
    res_valid   = 1'b0;
    res         = '0;
    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == BYTE_SYN) phase_nxt = PH_SYNS;
      end
      PH_SYNS: begin
        priority if (rx_byte == BYTE_SYN) phase_nxt = PH_SYNS;
        else if (rx_byte == BYTE_DLE) phase_nxt = PH_OPEN;
        else phase_nxt = PH_HUNT;
      end
      PH_OPEN: begin
        if (rx_byte == BYTE_STX) begin
          phase_nxt   = PH_BODY;
          count_nxt   = '0;
          dropped_nxt = 1'b0;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_BODY: begin
        if (rx_byte == BYTE_DLE) phase_nxt = PH_ESCAPE;
        else keep = 1'b1;
      end
      PH_ESCAPE: begin
        if (rx_byte == BYTE_DLE) begin
          phase_nxt = PH_BODY;
          keep      = 1'b1;
        end else begin
          // any other byte closes the frame
          phase_nxt        = PH_HUNT;
          res_valid        = 1'b1;
          res.record_kind  = sdsfr_pkg::KIND_END;
          res.frame_length = count_r;
          res.overflow     = dropped_r;
        end
      end
      default: phase_nxt = PH_HUNT;
    endcase

    if (keep) begin
      if (room) begin
        count_nxt       = count_r + 8'd1;
        res_valid       = 1'b1;
        res.record_kind = sdsfr_pkg::KIND_DATA;
        res.data_byte   = rx_byte;
      end else begin
        dropped_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
    end
  end

endmodule

### rtl/core/sdsfr_out_reg.sv
module sdsfr_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  sdsfr_pkg::result_t res,
  input  logic               out_stall,
  output logic               out_valid,
  output sdsfr_pkg::result_t out_res
);

  logic               valid_r, valid_nxt;
  sdsfr_pkg::result_t res_r;

  // load is only raised when the register is empty or being taken
  always_comb begin
    if (load) valid_nxt = 1'b1;
    else if (!out_stall) valid_nxt = 1'b0;
    else valid_nxt = valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### test/syn_dle_stx_frame_receiver_test.sv
module syn_dle_stx_frame_receiver_test;

  localparam int MAX_LEN = 128;

  // framing bytes on the serial line
  localparam logic [7:0] SYN = 8'h16;
  localparam logic [7:0] DLE = 8'h10;
  localparam logic [7:0] STX = 8'h02;
  localparam logic [7:0] ETX = 8'h03;

  // idle cycles after the last record: a byte sits in the input register after
  // it is taken, keep margin
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 500000;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNS,
    PH_OPEN,
    PH_BODY,
    PH_ESCAPE
  } rx_phase_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_record_kind;
  logic [7:0] out_data_byte;
  logic [7:0] out_frame_length;
  logic       out_overflow;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_max_payload = 8'h00;

  syn_dle_stx_frame_receiver #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_record_kind (out_record_kind),
    .out_data_byte   (out_data_byte),
    .out_frame_length(out_frame_length),
    .out_overflow    (out_overflow),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_max_payload (cfg_max_payload)
  );

  // bytes waiting to be sent, and records the parser is expected to emit
  logic [7:0]         rx_bytes_pending[$];
  sdsfr_pkg::result_t expected_records[$];

  int pushed_count   = 0;  // bytes queued for the sender
  int accepted_count = 0;  // bytes the block has taken
  int framed_count   = 0;  // bytes queued as part of a frame attempt
  int errors         = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  bit in_taken       = 1'b0;

  // parser shadow state
  rx_phase_e  rx_phase;
  logic [7:0] kept_count;
  logic       dropped;
  logic [7:0] max_payload_q;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Shadow parser: one call per accepted byte, pushes 0 or 1 records.
  // ---------------------------------------------------------------------
  function automatic logic [7:0] payload_limit();
    return (max_payload_q > MAX_LEN) ? 8'(MAX_LEN) : max_payload_q;
  endfunction

  // store a payload byte if the frame still has room, else mark overflow
  task automatic keep_payload(input logic [7:0] b);
    sdsfr_pkg::result_t rec;
    if (kept_count < payload_limit()) begin
      kept_count = kept_count + 8'd1;
      rec.record_kind  = sdsfr_pkg::KIND_DATA;
      rec.data_byte    = b;
      rec.frame_length = 8'd0;
      rec.overflow     = 1'b0;
      expected_records.push_back(rec);
    end else begin
      dropped = 1'b1;
    end
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    sdsfr_pkg::result_t rec;
    case (rx_phase)
      PH_HUNT: begin
        if (b == SYN) rx_phase = PH_SYNS;
      end
      PH_SYNS: begin
        // a bad byte is swallowed, not re-examined as a SYN
        if (b == DLE) rx_phase = PH_OPEN;
        else if (b != SYN) rx_phase = PH_HUNT;
      end
      PH_OPEN: begin
        if (b == STX) begin
          rx_phase   = PH_BODY;
          kept_count = 8'd0;
          dropped    = 1'b0;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
      PH_BODY: begin
        if (b == DLE) rx_phase = PH_ESCAPE;
        else keep_payload(b);
      end
      PH_ESCAPE: begin
        if (b == DLE) begin
          rx_phase = PH_BODY;
          keep_payload(b);
        end else begin
          // any non-DLE after an escape closes the frame
          rx_phase = PH_HUNT;
          rec.record_kind  = sdsfr_pkg::KIND_END;
          rec.data_byte    = 8'd0;
          rec.frame_length = kept_count;
          rec.overflow     = dropped;
          expected_records.push_back(rec);
        end
      end
      default: rx_phase = PH_HUNT;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Driver: new byte / stall decisions at the falling edge. A byte on the
  // line stays put until taken.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (rx_bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid   <= 1'b1;
          in_rx_byte <= rx_bytes_pending.pop_front();
        end else begin
          in_valid   <= 1'b0;
          in_rx_byte <= 8'($urandom);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Input monitor: track config writes and accepted bytes, run the shadow.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (!rst_n) begin
      rx_phase      = PH_HUNT;
      kept_count    = 8'd0;
      dropped       = 1'b0;
      max_payload_q = 8'd128;
    end else begin
      if (cfg_wr_en) max_payload_q = cfg_max_payload;
      if (in_taken) begin
        parse_rx_byte(in_rx_byte);
        accepted_count++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output monitor: compare each taken record with the oldest expectation.
  // Also owns the run-away guard.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    sdsfr_pkg::result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d records still expected", $time, expected_records.size());
      $display("CHECK FAILED");
      $finish;
    end else if (rst_n && out_valid && !out_stall) begin
      if (expected_records.size() == 0) begin
        $display("%0t: unexpected record, expected none, actual kind %b data %h len %0d ovf %b",
                 $time, out_record_kind, out_data_byte, out_frame_length, out_overflow);
        errors++;
      end else begin
        want = expected_records.pop_front();
        if (out_record_kind !== want.record_kind) begin
          $display("%0t: record_kind expected %b actual %b",
                   $time, want.record_kind, out_record_kind);
          errors++;
        end
        if (out_data_byte !== want.data_byte) begin
          $display("%0t: data_byte expected %h actual %h", $time, want.data_byte, out_data_byte);
          errors++;
        end
        if (out_frame_length !== want.frame_length) begin
          $display("%0t: frame_length expected %0d actual %0d",
                   $time, want.frame_length, out_frame_length);
          errors++;
        end
        if (out_overflow !== want.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time, want.overflow, out_overflow);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    rx_bytes_pending.push_back(b);
    pushed_count++;
  endtask

  // sender holds off until every byte is taken and every record is back,
  // then gives the parser time to settle on bytes that make no record
  task automatic wait_idle();
    do @(negedge clk); while (accepted_count != pushed_count || expected_records.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    @(negedge clk);
    cfg_wr_en       <= 1'b1;
    cfg_max_payload <= v;
    @(negedge clk);
    cfg_wr_en       <= 1'b0;
  endtask

  // payload mix leans on the framing codes
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(11))
      0:       return SYN;
      1:       return DLE;
      2:       return STX;
      3:       return ETX;
      default: return 8'($urandom);
    endcase
  endfunction

  // full frame: SYN run, DLE STX, stuffed payload, DLE + closer
  task automatic push_frame(input int n, input bit odd_close);
    int         first;
    logic [7:0] b;
    first = pushed_count;
    repeat ($urandom_range(1, 3)) push_byte(SYN);
    push_byte(DLE);
    push_byte(STX);
    repeat (n) begin
      b = payload_byte();
      if (b == DLE) push_byte(DLE);
      push_byte(b);
    end
    push_byte(DLE);
    if (odd_close) begin
      do b = 8'($urandom); while (b == DLE);
      push_byte(b);
    end else begin
      push_byte(ETX);
    end
    framed_count += pushed_count - first;
  endtask

  // mostly well-formed frames, some noise and broken headers;
  // a full drain halfway makes the sender wait for all records
  task automatic run_random(input logic [7:0] limit, input int s_idle, input int r_idle,
                            input int n_items);
    int         start;
    bit         paused;
    logic [7:0] b;
    wait_idle();
    write_limit(limit);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    start  = framed_count;
    paused = 1'b0;
    while (framed_count - start < n_items) begin
      if (!paused && framed_count - start >= n_items / 2) begin
        paused = 1'b1;
        wait_idle();
      end
      case ($urandom_range(19))
        0, 1: begin
          repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
        end
        2: begin
          // SYN then junk
          do b = 8'($urandom); while (b == SYN || b == DLE);
          push_byte(SYN);
          push_byte(b);
          framed_count += 2;
        end
        3: begin
          // SYN DLE then something other than STX
          do b = 8'($urandom); while (b == STX);
          push_byte(SYN);
          push_byte(DLE);
          push_byte(b);
          framed_count += 3;
        end
        4: push_frame($urandom_range(0, 12), 1'b1);
        default: begin
          if ($urandom_range(9) < 8) push_frame($urandom_range(0, 12), 1'b0);
          else push_frame($urandom_range(0, 140), 1'b0);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    send_idle_pct = 20;
    recv_idle_pct = 51;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset limit of 128
    push_byte(8'h00);                    // noise while hunting
    push_byte(8'hFF);
    push_byte(SYN); push_byte(8'hFF);    // junk after SYN
    push_byte(SYN); push_byte(DLE);      // junk after DLE is a SYN, swallowed,
    push_byte(SYN); push_byte(DLE);      // so this DLE STX opens nothing
    push_byte(STX);
    push_byte(SYN); push_byte(SYN); push_byte(DLE); push_byte(STX);
    push_byte(8'h00); push_byte(8'hFF);
    push_byte(DLE); push_byte(DLE);      // stuffed DLE
    push_byte(SYN);                      // SYN as payload
    push_byte(DLE); push_byte(ETX);
    push_byte(SYN); push_byte(DLE); push_byte(STX);
    push_byte(DLE); push_byte(8'h55);    // non-ETX closer
    push_byte(SYN); push_byte(DLE); push_byte(STX);   // hunt right after closer
    push_byte(DLE); push_byte(ETX);      // empty frame
    wait_idle();

    // zero limit keeps nothing, flags overflow
    write_limit(8'd0);
    push_frame(2, 1'b0);
    wait_idle();

    // limit of one: first byte kept, rest dropped
    write_limit(8'd1);
    push_frame(3, 1'b0);

    // random phases: receiver-heavy idling, then sender-heavy, then none
    run_random(8'd3,   20, 51, 400);
    run_random(8'd128, 20, 51, 300);
    run_random(8'd255, 51, 20, 500);   // clamps to the parameter
    run_random(8'd1,   51, 20, 200);
    run_random(8'd0,    0,  0, 200);
    run_random(8'd200,  0,  0, 400);

    wait_idle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/sdsfr_pkg.sv
rtl/core/sdsfr_parser.sv
rtl/core/sdsfr_out_reg.sv
rtl/core/syn_dle_stx_frame_receiver.sv
test/syn_dle_stx_frame_receiver_test.sv
